// ===== hdl/mwt_pkg.sv =====
// ----------------------------------------------------------------------------
// mwt_pkg
// Shared constants, codes and types of the MAC whitelist table.
// ----------------------------------------------------------------------------
`default_nettype none

package mwt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = 5;
   localparam int MAC_W       = 48;
   localparam int FUNC_W      = 3;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LIST   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MATCH = 4'b0010,
      ST_APPLY = 4'b0100,
      ST_LIST  = 4'b1000
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic               match;
      logic               append;
      logic               remove;
      logic               clear;
      logic               tap_load;
      logic               tap_shift;
      logic [MAC_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/mwt_req_if.sv =====
// ----------------------------------------------------------------------------
// mwt_req_if
// Request channel: operation, address and list limit.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwt_req_if
   import mwt_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [MAC_W-1:0]   mac_in;
   logic [COUNT_W-1:0] list_limit;

   modport source (output valid, func, mac_in, list_limit, input ready);
   modport sink   (input valid, func, mac_in, list_limit, output ready);
endinterface

`default_nettype wire

// ===== hdl/mwt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mwt_rsp_if
// Response channel: status, count and listed entries.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwt_rsp_if
   import mwt_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               ok;
   logic [COUNT_W-1:0] entry_count;
   logic [MAC_W-1:0]   entry_mac;
   logic               entry_valid;
   logic               last;

   modport source (output valid, ok, entry_count, entry_mac, entry_valid, last,
                   input ready);
   modport sink   (input valid, ok, entry_count, entry_mac, entry_valid, last,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/mwt_cell.sv =====
// ----------------------------------------------------------------------------
// mwt_cell
// One table slot: compare, append, clear, shift-down on remove, list tap shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mwt_cell
   import mwt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [IDX_W-1:0]   cell_index,
   input  wire cell_ctrl_type      ctrl,
   input  wire logic [MAC_W-1:0]   next_slot_in,
   input  wire logic [MAC_W-1:0]   next_tap_in,
   input  wire logic               seen_in,
   output logic [MAC_W-1:0]        slot_out,
   output logic [MAC_W-1:0]        tap_out,
   output logic                    seen_out
);

   logic [MAC_W-1:0] slot_ff, slot_in;
   logic [MAC_W-1:0] tap_ff, tap_in;
   logic             hit_ff, hit_in;
   logic             occupied;

   assign occupied = COUNT_W'(cell_index) < ctrl.count;
   assign seen_out = seen_in | hit_ff;
   assign slot_out = slot_ff;
   assign tap_out  = tap_ff;

   always_comb begin
      hit_in  = hit_ff;
      slot_in = slot_ff;
      tap_in  = tap_ff;
      if (ctrl.match) begin
         hit_in = occupied && (slot_ff == ctrl.key);
      end
      if (ctrl.clear) begin
         slot_in = '0;
      end else if (ctrl.remove && seen_out) begin
         slot_in = next_slot_in;
      end else if (ctrl.append && (COUNT_W'(cell_index) == ctrl.count)) begin
         slot_in = ctrl.key;
      end
      if (ctrl.tap_load) begin
         tap_in = slot_ff;
      end else if (ctrl.tap_shift) begin
         tap_in = next_tap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         slot_ff <= '0;
      end else begin
         hit_ff  <= hit_in;
         slot_ff <= slot_in;
      end
      tap_ff <= tap_in;
   end

endmodule

`default_nettype wire

// ===== hdl/mac_whitelist_table_core.sv =====
// ----------------------------------------------------------------------------
// mac_whitelist_table_core
// Packed MAC address whitelist built as a row of slot cells.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready); each carries func, mac_in and
// list_limit. Responses leave on rsp through one output register.
// Add, remove, lookup, clear and unused codes give one response with
// last set. List gives min(list_limit, held entries) responses in slot
// order, the final one flagged by last, or one empty response.
// One request is in work at a time. After a transfer on req the cells
// compare the address in parallel in ST_MATCH and register their hits;
// then in ST_APPLY, once the output register is free, the table is
// updated and the response registered. A list then shifts its entries
// out of the cells' tap chain in ST_LIST, one per cycle while the output
// register is free. Reset empties the table and the output register.
// While the receiver holds rsp.ready low the sequencer waits with its
// next response; req is taken again as soon as the last response of a
// request is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_whitelist_table_core
   import mwt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mwt_req_if.sink   req,
   mwt_rsp_if.source rsp
);

   state_type          state_ff, state_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [MAC_W-1:0]   key_ff, key_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [MAC_W-1:0]   rsp_mac_ff, rsp_mac_in;
   logic               rsp_entry_valid_ff, rsp_entry_valid_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_ctrl_type      ctrl;
   logic               out_free;
   logic               any_hit;
   logic               rsp_load;
   logic [COUNT_W-1:0] list_n;

   logic [MAC_W-1:0]   slot_q [MAX_ENTRIES];
   logic [MAC_W-1:0]   tap_q  [MAX_ENTRIES];
   logic               seen   [MAX_ENTRIES+1];

   // cell row
   assign seen[0] = 1'b0;
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [MAC_W-1:0] next_slot;
      logic [MAC_W-1:0] next_tap;
      if (g == MAX_ENTRIES - 1) begin : g_end
         assign next_slot = '0;
         assign next_tap  = '0;
      end else begin : g_mid
         assign next_slot = slot_q[g+1];
         assign next_tap  = tap_q[g+1];
      end
      mwt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (IDX_W'(g)),
         .ctrl         (ctrl),
         .next_slot_in (next_slot),
         .next_tap_in  (next_tap),
         .seen_in      (seen[g]),
         .slot_out     (slot_q[g]),
         .tap_out      (tap_q[g]),
         .seen_out     (seen[g+1])
      );
   end

   assign any_hit  = seen[MAX_ENTRIES];
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign list_n   = (count_ff < limit_ff) ? count_ff : limit_ff;

   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in           = state_ff;
      func_in            = func_ff;
      key_in             = key_ff;
      limit_in           = limit_ff;
      count_in           = count_ff;
      remain_in          = remain_ff;
      rsp_load           = 1'b0;
      rsp_ok_in          = rsp_ok_ff;
      rsp_count_in       = rsp_count_ff;
      rsp_mac_in         = rsp_mac_ff;
      rsp_entry_valid_in = rsp_entry_valid_ff;
      rsp_last_in        = rsp_last_ff;

      ctrl           = '0;
      ctrl.key       = key_ff;
      ctrl.count     = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in  = req.func;
               key_in   = req.mac_in;
               limit_in = req.list_limit;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            ctrl.match = 1'b1;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               rsp_ok_in          = 1'b0;
               rsp_mac_in         = '0;
               rsp_entry_valid_in = 1'b0;
               rsp_last_in        = 1'b1;
               rsp_load           = 1'b1;
               state_in           = ST_IDLE;
               case (func_ff)
                  FUNC_ADD: begin
                     if (any_hit) begin
                        rsp_ok_in = 1'b1;
                     end else if (count_ff < COUNT_W'(MAX_ENTRIES)) begin
                        ctrl.append = 1'b1;
                        count_in    = count_ff + COUNT_W'(1);
                        rsp_ok_in   = 1'b1;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (any_hit) begin
                        ctrl.remove = 1'b1;
                        count_in    = count_ff - COUNT_W'(1);
                        rsp_ok_in   = 1'b1;
                     end
                  end
                  FUNC_LOOKUP: begin
                     rsp_ok_in = any_hit;
                  end
                  FUNC_LIST: begin
                     if (list_n != '0) begin
                        ctrl.tap_load = 1'b1;
                        remain_in     = list_n;
                        rsp_load      = 1'b0;
                        state_in      = ST_LIST;
                     end
                  end
                  FUNC_CLEAR: begin
                     ctrl.clear = 1'b1;
                     count_in   = '0;
                     rsp_ok_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         ST_LIST: begin
            if (out_free) begin
               ctrl.tap_shift     = 1'b1;
               rsp_load           = 1'b1;
               rsp_ok_in          = 1'b1;
               rsp_count_in       = count_ff;
               rsp_mac_in         = tap_q[0];
               rsp_entry_valid_in = 1'b1;
               rsp_last_in        = (remain_ff == COUNT_W'(1));
               remain_in          = remain_ff - COUNT_W'(1);
               if (remain_ff == COUNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff            <= func_in;
      key_ff             <= key_in;
      limit_ff           <= limit_in;
      rsp_ok_ff          <= rsp_ok_in;
      rsp_count_ff       <= rsp_count_in;
      rsp_mac_ff         <= rsp_mac_in;
      rsp_entry_valid_ff <= rsp_entry_valid_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ok          = rsp_ok_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.entry_mac   = rsp_mac_ff;
   assign rsp.entry_valid = rsp_entry_valid_ff;
   assign rsp.last        = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_ENTRIES))
      else $error("held count beyond table size");

   a_list_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST) |-> (remain_ff != '0))
      else $error("list state with nothing left to emit");

   a_accept_match: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == ST_MATCH))
      else $error("request transfer not followed by compare");

   a_entry_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_entry_valid_ff) |-> rsp_ok_ff)
      else $error("listed entry without ok");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MAC whitelist table core.
// ----------------------------------------------------------------------------
// Requests go in through bursts with random gaps, and the response side
// stalls on a pattern of its own. Every accepted request updates a shadow
// copy of the table and queues the responses it should produce. Each
// response transfer is checked field by field against the oldest one queued.
// A directed pass fills, overfills, lists and drains the table, then about
// 120 random requests follow.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import mwt_pkg::*;
   ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0] FUNC_RESERVED_FIRST = FUNC_CLEAR + 1'b1;
   localparam logic [FUNC_W-1:0] FUNC_RESERVED_LAST  = '1;
   localparam int RANDOM_REQUESTS = 120;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] count;
      logic [MAC_W-1:0]   mac;
      logic               valid;
      logic               last;
   } rsp_item_type;

   class whitelist_scoreboard;
      logic [MAC_W-1:0] slots [MAX_ENTRIES];
      int               held;
      rsp_item_type     expected_q [$];
      int unsigned      mismatches;

      function new();
         empty_table();
         mismatches = 0;
      endfunction

      function void empty_table();
         foreach (slots[i]) slots[i] = '0;
         held = 0;
      endfunction

      function int find_slot(logic [MAC_W-1:0] mac);
         for (int i = 0; i < held; i++) begin
            if (slots[i] == mac) return i;
         end
         return -1;
      endfunction

      function string describe(rsp_item_type r);
         return $sformatf("ok=%0b count=%0d mac=%012h valid=%0b last=%0b",
                          r.ok, r.count, r.mac, r.valid, r.last);
      endfunction

      // update the shadow table and queue what this request produces
      function void note_request(logic [FUNC_W-1:0] func, logic [MAC_W-1:0] mac,
                                 logic [COUNT_W-1:0] limit);
         rsp_item_type r;
         int           pos;
         int           n;
         r = '{ok: 1'b0, count: '0, mac: '0, valid: 1'b0, last: 1'b1};
         case (func)
            FUNC_ADD: begin
               if (find_slot(mac) >= 0) begin
                  r.ok = 1'b1;
               end else if (held < MAX_ENTRIES) begin
                  slots[held] = mac;
                  held++;
                  r.ok = 1'b1;
               end
            end
            FUNC_REMOVE: begin
               pos = find_slot(mac);
               if (pos >= 0) begin
                  for (int i = pos; i + 1 < held; i++) slots[i] = slots[i + 1];
                  held--;
                  slots[held] = '0;
                  r.ok = 1'b1;
               end
            end
            FUNC_LOOKUP: begin
               r.ok = find_slot(mac) >= 0;
            end
            FUNC_LIST: begin
               n = (held < int'(limit)) ? held : int'(limit);
               if (n > MAX_ENTRIES) n = MAX_ENTRIES;
               for (int i = 0; i < n; i++) begin
                  expected_q.push_back('{ok: 1'b1, count: COUNT_W'(held), mac: slots[i],
                                         valid: 1'b1, last: (i == n - 1)});
               end
               if (n > 0) return;
            end
            FUNC_CLEAR: begin
               empty_table();
               r.ok = 1'b1;
            end
            default: ;
         endcase
         r.count = COUNT_W'(held);
         expected_q.push_back(r);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response with none expected: %s", $realtime, describe(got));
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response mismatch\n  expected %s\n  actual   %s",
                        $realtime, describe(want), describe(got));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   mwt_req_if req_ch ();
   mwt_rsp_if rsp_ch ();

   mac_whitelist_table_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   whitelist_scoreboard sb = new();

   int burst_left = 0;
   int idle_cycles = 0;
   int rsp_mode = 0;
   int rsp_mode_left = 0;
   int rsp_stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: stretches of always-ready, random stalls and long stalls
   always @(negedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_mode      = $urandom_range(0, 2);
         rsp_mode_left = $urandom_range(10, 60);
      end
      rsp_mode_left--;
      case (rsp_mode)
         0: rsp_ch.ready = 1'b1;
         1: rsp_ch.ready = $urandom_range(0, 3) != 0;
         default: begin
            if (rsp_stall_left > 0) begin
               rsp_ch.ready = 1'b0;
               rsp_stall_left--;
            end else begin
               rsp_ch.ready   = 1'b1;
               rsp_stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            end
         end
      endcase
   end

   // response check and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_response('{ok: rsp_ch.ok, count: rsp_ch.entry_count,
                             mac: rsp_ch.entry_mac, valid: rsp_ch.entry_valid,
                             last: rsp_ch.last});
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   task automatic send_request(logic [FUNC_W-1:0] func, logic [MAC_W-1:0] mac,
                               logic [COUNT_W-1:0] limit);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_ch.valid      = 1'b1;
      req_ch.func       = func;
      req_ch.mac_in     = mac;
      req_ch.list_limit = limit;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(func, mac, limit);
      burst_left--;
   endtask

   function automatic logic [MAC_W-1:0] random_mac();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   function automatic logic [MAC_W-1:0] held_or_random_mac();
      if (sb.held > 0 && $urandom_range(0, 9) < 7)
         return sb.slots[$urandom_range(0, sb.held - 1)];
      return random_mac();
   endfunction

   initial begin
      int               pick;
      logic [FUNC_W-1:0] func;
      logic [COUNT_W-1:0] limit;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_ADD;
      req_ch.mac_in     = '0;
      req_ch.list_limit = '0;
      rsp_ch.ready      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table: list, lookup of the zero address, remove
      send_request(FUNC_LIST, '0, 5'd16);
      send_request(FUNC_LOOKUP, '0, '0);
      send_request(FUNC_REMOVE, '0, '0);
      // extreme addresses and a duplicate add
      send_request(FUNC_ADD, '0, '0);
      send_request(FUNC_ADD, '1, '0);
      send_request(FUNC_ADD, '1, '1);
      // fill up, then one add past full
      for (int i = 0; i < MAX_ENTRIES - 2; i++) begin
         if (i == 0)
            send_request(FUNC_ADD, 48'hAAAA_AAAA_AAAA, '0);
         else if (i == 1)
            send_request(FUNC_ADD, 48'h5555_5555_5555, '0);
         else
            send_request(FUNC_ADD, random_mac(), '0);
      end
      send_request(FUNC_ADD, random_mac(), '0);
      send_request(FUNC_LIST, random_mac(), '1);
      send_request(FUNC_LOOKUP, 48'hAAAA_AAAA_AAAA, '0);
      // removal from middle, front and back
      send_request(FUNC_REMOVE, sb.slots[5], '0);
      send_request(FUNC_REMOVE, sb.slots[0], '0);
      send_request(FUNC_REMOVE, sb.slots[sb.held - 1], '0);
      send_request(FUNC_LIST, '0, '0);
      send_request(FUNC_LIST, '0, 5'd3);
      send_request(FUNC_RESERVED_LAST, '1, '1);
      send_request(FUNC_RESERVED_FIRST, '0, '0);
      send_request(FUNC_CLEAR, '1, '1);
      send_request(FUNC_LIST, '0, 5'd16);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pick  = $urandom_range(0, 99);
         limit = '0;
         if (pick < 38)
            func = FUNC_ADD;
         else if (pick < 58)
            func = FUNC_REMOVE;
         else if (pick < 76)
            func = FUNC_LOOKUP;
         else if (pick < 93)
            func = FUNC_LIST;
         else if (pick < 96)
            func = FUNC_CLEAR;
         else
            func = FUNC_RESERVED_FIRST + 3'($urandom_range(0, FUNC_RESERVED_LAST
                                                              - FUNC_RESERVED_FIRST));
         if (func == FUNC_LIST) begin
            if ($urandom_range(0, 9) < 7)
               limit = COUNT_W'($urandom_range(0, sb.held + 1));
            else
               limit = COUNT_W'($urandom_range(0, 31));
         end else if ($urandom_range(0, 7) == 0) begin
            limit = COUNT_W'($urandom_range(0, 31));
         end
         if (func == FUNC_ADD && $urandom_range(0, 4) != 0)
            send_request(func, random_mac(), limit);
         else
            send_request(func, held_or_random_mac(), limit);
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
